@@ rtl/char_lcd_terminal_cursor_core_defines.svh @@
// assertion macros for the character lcd terminal cursor core checker
`ifndef CHAR_LCD_TERMINAL_CURSOR_CORE_DEFINES_SVH
`define CHAR_LCD_TERMINAL_CURSOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CLT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clt assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clt assertion failed");

`endif

@@ rtl/clt_pkg.sv @@
// shared types and constants of the character lcd terminal cursor core
package clt_pkg;

	localparam int MAX_COLUMNS_DEF = 40;
	localparam int CHAR_W = 8;
	localparam int COL_W = 6;
	localparam int LCNT_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	localparam logic [CHAR_W-1:0] CMD_SET_ADDRESS = 8'h80;
	localparam logic [CHAR_W-1:0] LINE_STRIDE = 8'h40;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_FORMFEED = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_LINEFEED = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_VTAB = 8'h0B;

	localparam logic [COL_W-1:0] COLUMN_COUNT_RST = 6'd16;
	localparam logic [LCNT_W-1:0] LINE_COUNT_RST = 2'd2;
	localparam int MIN_COLUMNS = 8;

	localparam logic REG_COLUMN_COUNT = 1'b0;
	localparam logic REG_LINE_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHAR,
		ST_CLEAR,
		ST_MOVE
	} clt_state_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_CHAR,
		ACT_CLEAR,
		ACT_MOVE
	} clt_action_t;

	typedef struct packed {
		logic accept;
		logic emit_char;
		logic emit_space;
		logic emit_move;
	} clt_cmd_t;

	typedef struct packed {
		clt_action_t action;
		logic last_space;
		logic out_free;
	} clt_status_t;

endpackage

@@ rtl/clt_ifs.sv @@
// valid/ready channel interfaces for characters in and bus transfers out
interface clt_char_if;
	import clt_pkg::*;
	logic valid;
	logic ready;
	logic [CHAR_W-1:0] character;
	modport source (output valid, output character, input ready);
	modport sink (input valid, input character, output ready);
endinterface

interface clt_xfer_if;
	import clt_pkg::*;
	logic valid;
	logic ready;
	logic register_select;
	logic [CHAR_W-1:0] bus_byte;
	logic last_of_run;
	modport source (output valid, output register_select, output bus_byte,
		output last_of_run, input ready);
	modport sink (input valid, input register_select, input bus_byte,
		input last_of_run, output ready);
endinterface

@@ rtl/char_lcd_terminal_cursor_core.sv @@
// top level of the character lcd terminal cursor core
// usage:
//   chars carries one character byte per transfer; xfers carries the
//   resulting controller writes (register select, byte, last of run).
//   the apb port holds column_count at address 0 and line_count at 4.
// timing:
//   a character is taken when the core is idle; the state machine then
//   loads one output transfer per cycle into the output register while
//   it is free; the state register lies between the input and the result.
//   plain characters and cursor moves give one transfer each.
//   vertical tab gives one transfer per space to the end of the line
//   plus the address command, set by the space counter.
//   items with no result give no transfer.
// stalls:
//   when xfers is not ready the output register holds its transfer and
//   the sequencer waits; a new character is still taken once the last
//   transfer of the previous one sits in the output register.
// reset:
//   arst_n clears the cursor to line 0 column 0, empties the output
//   register and sets the registers to 16 columns and 2 lines.
module char_lcd_terminal_cursor_core #(
	parameter int MAX_COLUMNS = clt_pkg::MAX_COLUMNS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [clt_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [clt_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [clt_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	clt_char_if.sink                        chars,
	clt_xfer_if.source                      xfers
);
	import clt_pkg::*;

	logic [COL_W-1:0] column_count;
	logic [LCNT_W-1:0] line_count;
	clt_cmd_t cmd;
	clt_status_t status;

	clt_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.column_count (column_count),
		.line_count   (line_count)
	);

	clt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.status   (status),
		.cmd      (cmd)
	);

	clt_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.character       (chars.character),
		.column_count    (column_count),
		.line_count      (line_count),
		.cmd             (cmd),
		.status          (status),
		.out_valid       (xfers.valid),
		.out_ready       (xfers.ready),
		.register_select (xfers.register_select),
		.bus_byte        (xfers.bus_byte),
		.last_of_run     (xfers.last_of_run)
	);
endmodule

@@ rtl/clt_cfg_regs.sv @@
// apb configuration registers: column count and line count
module clt_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [clt_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [clt_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [clt_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic [clt_pkg::COL_W-1:0]        column_count,
	output logic [clt_pkg::LCNT_W-1:0]       line_count
);
	import clt_pkg::*;

	logic [COL_W-1:0] column_count_q;
	logic [LCNT_W-1:0] line_count_q;
	logic reg_index;
	logic wr_en;

	assign reg_index = paddr[2];
	assign wr_en = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COLUMN_COUNT_RST;
			line_count_q <= LINE_COUNT_RST;
		end else if (wr_en) begin
			case (reg_index)
				REG_COLUMN_COUNT: column_count_q <= pwdata[COL_W-1:0];
				REG_LINE_COUNT:   line_count_q <= pwdata[LCNT_W-1:0];
				default:          column_count_q <= column_count_q;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_COLUMN_COUNT: prdata = CFG_DATA_W'(column_count_q);
			REG_LINE_COUNT:   prdata = CFG_DATA_W'(line_count_q);
			default:          prdata = '0;
		endcase
	end

	assign column_count = column_count_q;
	assign line_count = line_count_q;
endmodule

@@ rtl/clt_ctrl.sv @@
// sequencing state machine for character, clear-to-end and cursor moves
module clt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  clt_pkg::clt_status_t status,
	output clt_pkg::clt_cmd_t    cmd
);
	import clt_pkg::*;

	clt_state_t state_q;
	clt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (status.action)
						ACT_CHAR:  state_d = ST_CHAR;
						ACT_CLEAR: state_d = ST_CLEAR;
						ACT_MOVE:  state_d = ST_MOVE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_CHAR: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (status.out_free && status.last_space) state_d = ST_MOVE;
			end
			ST_MOVE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.accept = in_valid && (state_q == ST_IDLE);
		cmd.emit_char = (state_q == ST_CHAR) && status.out_free;
		cmd.emit_space = (state_q == ST_CLEAR) && status.out_free;
		cmd.emit_move = (state_q == ST_MOVE) && status.out_free;
	end
endmodule

@@ rtl/clt_datapath.sv @@
// cursor state, character decode, space counter and output register
module clt_datapath #(
	parameter int MAX_COLUMNS = clt_pkg::MAX_COLUMNS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [clt_pkg::CHAR_W-1:0]   character,
	input  logic [clt_pkg::COL_W-1:0]    column_count,
	input  logic [clt_pkg::LCNT_W-1:0]   line_count,
	input  clt_pkg::clt_cmd_t            cmd,
	output clt_pkg::clt_status_t         status,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         register_select,
	output logic [clt_pkg::CHAR_W-1:0]   bus_byte,
	output logic                         last_of_run
);
	import clt_pkg::*;

	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int CMP_W = (CNT_W > COL_W) ? CNT_W : COL_W;

	logic [COL_W-1:0] col_q;
	logic line_q;
	logic [CHAR_W-1:0] ch_q;
	logic tgt_line_q;
	logic [COL_W-1:0] tgt_col_q;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic rs_q;
	logic [CHAR_W-1:0] byte_q;
	logic last_q;

	logic [CMP_W-1:0] cols_w;
	logic [CMP_W-1:0] col_w;
	logic [LCNT_W-1:0] lines;
	logic at_last;
	logic [LCNT_W-1:0] req_line;
	logic [COL_W-1:0] req_col;
	logic [LCNT_W-1:0] wrap_line;
	logic [COL_W-1:0] wrap_col;
	clt_action_t action;
	logic out_free;

	// clamp the configured geometry
	always_comb begin
		if (CMP_W'(column_count) < CMP_W'(MIN_COLUMNS)) begin
			cols_w = CMP_W'(MIN_COLUMNS);
		end else if (CMP_W'(column_count) > CMP_W'(MAX_COLUMNS)) begin
			cols_w = CMP_W'(MAX_COLUMNS);
		end else begin
			cols_w = CMP_W'(column_count);
		end
		case (line_count)
			2'd0:    lines = 2'd1;
			2'd3:    lines = 2'd2;
			default: lines = line_count;
		endcase
	end

	assign col_w = CMP_W'(col_q);
	assign at_last = col_w >= (cols_w - CMP_W'(1));

	// decode the incoming character against the current cursor
	always_comb begin
		action = ACT_NONE;
		req_line = {1'b0, line_q};
		req_col = col_q;
		case (character)
			CH_BACKSPACE: begin
				if (col_q != '0) begin
					action = ACT_MOVE;
					req_col = col_q - COL_W'(1);
				end
			end
			CH_FORMFEED: begin
				action = ACT_MOVE;
				req_line = '0;
				req_col = '0;
			end
			CH_LINEFEED: begin
				action = ACT_MOVE;
				req_line = {1'b0, line_q} + LCNT_W'(1);
				req_col = '0;
			end
			CH_RETURN: begin
				if (col_q != '0) begin
					action = ACT_MOVE;
					req_col = '0;
				end
			end
			CH_VTAB: begin
				if (!at_last) action = ACT_CLEAR;
			end
			default: begin
				if (!at_last) action = ACT_CHAR;
			end
		endcase
	end

	// wrap the target past the last column and the last line
	always_comb begin
		wrap_line = req_line;
		wrap_col = req_col;
		if (CMP_W'(req_col) >= cols_w) begin
			wrap_line = req_line + LCNT_W'(1);
			wrap_col = '0;
		end
		if (wrap_line >= lines) wrap_line = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q <= character;
			tgt_line_q <= wrap_line[0];
			tgt_col_q <= wrap_col;
			cnt_q <= CNT_W'(cols_w - col_w);
		end else if (cmd.emit_space) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			line_q <= 1'b0;
		end else if (cmd.emit_char) begin
			col_q <= col_q + COL_W'(1);
		end else if (cmd.emit_move) begin
			col_q <= tgt_col_q;
			line_q <= tgt_line_q;
		end
	end

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_char || cmd.emit_space || cmd.emit_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_char) begin
			rs_q <= 1'b1;
			byte_q <= ch_q;
			last_q <= 1'b1;
		end else if (cmd.emit_space) begin
			rs_q <= 1'b1;
			byte_q <= CH_SPACE;
			last_q <= 1'b0;
		end else if (cmd.emit_move) begin
			rs_q <= 1'b0;
			byte_q <= CMD_SET_ADDRESS + (tgt_line_q ? LINE_STRIDE : '0)
				+ CHAR_W'(tgt_col_q);
			last_q <= 1'b1;
		end
	end

	assign status.action = action;
	assign status.last_space = (cnt_q == CNT_W'(1));
	assign status.out_free = out_free;

	assign out_valid = out_valid_q;
	assign register_select = rs_q;
	assign bus_byte = byte_q;
	assign last_of_run = last_q;
endmodule

@@ rtl/clt_checker.sv @@
// port-level assertion checker for the cursor core, with its bind
`include "char_lcd_terminal_cursor_core_defines.svh"

module clt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          register_select,
	input logic [clt_pkg::CHAR_W-1:0]    bus_byte,
	input logic                          last_of_run
);
	import clt_pkg::*;

	// stalled transfer holds
	`CLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bus_byte))
	// a cursor address command always closes a run
	`CLT_ASSERT_NOW(a_cmd_last, out_valid && !register_select, last_of_run && bus_byte[7])
	// data writes inside a run are clearing spaces
	`CLT_ASSERT_NOW(a_fill_space, out_valid && register_select && !last_of_run,
		bus_byte == CH_SPACE)
	// a clearing space that is taken is followed by another space, a command or no transfer
	`CLT_ASSERT_NEXT(a_fill_next, out_valid && out_ready && register_select && !last_of_run,
		!out_valid || !register_select || !last_of_run || bus_byte == CH_SPACE)
endmodule

bind char_lcd_terminal_cursor_core clt_checker u_clt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (xfers.valid),
	.out_ready       (xfers.ready),
	.register_select (xfers.register_select),
	.bus_byte        (xfers.bus_byte),
	.last_of_run     (xfers.last_of_run)
);
